### rtl/ttc_pkg.sv
// Package for the thermistor temperature converter.
// Holds field widths, register and status codes, shared structs and the engine state type.
// No dependencies.
package ttc_pkg;

    // Default full-scale ADC count.
    localparam int ADC_FULL_SCALE_DEF = 4095;

    // Configuration port.
    localparam int PADDR_W = 6;
    localparam int PDATA_W = 64;

    // Field widths.
    localparam int RAW_W    = 16;
    localparam int TEMP_W   = 18;
    localparam int STAT_W   = 2;
    localparam int MODE_W   = 2;
    localparam int PULLUP_W = 20;
    localparam int COEF_W   = 56;
    localparam int CAL_W    = 11;

    // Width of the divider arithmetic and of the log operands.
    localparam int DN_W  = 24;
    localparam int LOG_W = 20;

    // Depth of the job queue between front and back.
    localparam int QDEPTH = 2;

    // Sensor modes.
    localparam logic [MODE_W-1:0] MODE_TC    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_THERM = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FIXED = 2'd2;

    // Conversion status codes.
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_DEN   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_RECIP = 2'd2;
    localparam logic [STAT_W-1:0] STAT_RES   = 2'd3;

    // Register indexes.
    localparam logic [2:0] REG_MODE     = 3'd0;
    localparam logic [2:0] REG_PULLUP   = 3'd1;
    localparam logic [2:0] REG_COEF_A   = 3'd2;
    localparam logic [2:0] REG_COEF_B   = 3'd3;
    localparam logic [2:0] REG_COEF_C   = 3'd4;
    localparam logic [2:0] REG_LOW_CAL  = 3'd5;
    localparam logic [2:0] REG_HIGH_CAL = 3'd6;

    // Fixed temperatures in sixteenths of a degree.
    localparam logic signed [TEMP_W-1:0] TEMP_ABS_ZERO = -18'sd4370;
    localparam logic signed [TEMP_W-1:0] TEMP_HOT      = 18'sd32000;
    localparam logic signed [TEMP_W-1:0] TEMP_ROOM     = 18'sd400;
    localparam logic signed [TEMP_W-1:0] TEMP_MAX      = 18'sd131071;

    // Configuration register file contents.
    typedef struct packed {
        logic [MODE_W-1:0]          sensor_mode;
        logic [PULLUP_W-1:0]        pullup_ohms;
        logic signed [COEF_W-1:0]   coef_a;
        logic signed [COEF_W-1:0]   coef_b;
        logic signed [COEF_W-1:0]   coef_c;
        logic signed [CAL_W-1:0]    adc_low_cal;
        logic signed [CAL_W-1:0]    adc_high_cal;
    } t_cfg;

    // One classified job: either a finished result or a thermistor conversion.
    typedef struct packed {
        logic                       therm;
        logic signed [TEMP_W-1:0]   temp;
        logic [STAT_W-1:0]          status;
        logic [LOG_W-1:0]           d_val;
        logic [LOG_W-1:0]           n_val;
    } t_job;

    // Conversion engine states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_LOG,
        S_SUM,
        S_MSET,
        S_MPP,
        S_MFIN,
        S_ADD1,
        S_ADD2,
        S_DIV,
        S_RND1,
        S_RND2,
        S_RND3,
        S_DONE
    } t_state;

endpackage

### rtl/ttc_regs.sv
// Configuration register file of the thermistor temperature converter.
// APB-style write and read port; depends on ttc_pkg.
module ttc_regs import ttc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    t_cfg       r_cfg;
    t_cfg       n_cfg;
    logic       w_wr;
    logic [2:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign w_idx  = paddr[PADDR_W-1:3];
    assign o_cfg  = r_cfg;

    // Next register contents for a write transfer.
    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            unique case (w_idx)
                REG_MODE:     n_cfg.sensor_mode  = pwdata[MODE_W-1:0];
                REG_PULLUP:   n_cfg.pullup_ohms  = pwdata[PULLUP_W-1:0];
                REG_COEF_A:   n_cfg.coef_a       = pwdata[COEF_W-1:0];
                REG_COEF_B:   n_cfg.coef_b       = pwdata[COEF_W-1:0];
                REG_COEF_C:   n_cfg.coef_c       = pwdata[COEF_W-1:0];
                REG_LOW_CAL:  n_cfg.adc_low_cal  = pwdata[CAL_W-1:0];
                REG_HIGH_CAL: n_cfg.adc_high_cal = pwdata[CAL_W-1:0];
                default: ;
            endcase
        end
    end

    // Register file with its reset values.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sensor_mode  <= MODE_FIXED;
            r_cfg.pullup_ohms  <= 20'd4700;
            r_cfg.coef_a       <= '0;
            r_cfg.coef_b       <= '0;
            r_cfg.coef_c       <= '0;
            r_cfg.adc_low_cal  <= '0;
            r_cfg.adc_high_cal <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Read data, zero extended.
    always_comb begin
        unique case (w_idx)
            REG_MODE:     prdata = {{(PDATA_W-MODE_W){1'b0}}, r_cfg.sensor_mode};
            REG_PULLUP:   prdata = {{(PDATA_W-PULLUP_W){1'b0}}, r_cfg.pullup_ohms};
            REG_COEF_A:   prdata = {{(PDATA_W-COEF_W){1'b0}}, r_cfg.coef_a};
            REG_COEF_B:   prdata = {{(PDATA_W-COEF_W){1'b0}}, r_cfg.coef_b};
            REG_COEF_C:   prdata = {{(PDATA_W-COEF_W){1'b0}}, r_cfg.coef_c};
            REG_LOW_CAL:  prdata = {{(PDATA_W-CAL_W){1'b0}}, r_cfg.adc_low_cal};
            REG_HIGH_CAL: prdata = {{(PDATA_W-CAL_W){1'b0}}, r_cfg.adc_high_cal};
            default:      prdata = '0;
        endcase
    end

endmodule

### rtl/ttc_front.sv
// Front end of the thermistor temperature converter: classifies readings and queues jobs.
// Depends on ttc_pkg.
module ttc_front import ttc_pkg::*; #(
    parameter int ADC_FULL_SCALE = ADC_FULL_SCALE_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cfg                    i_cfg,
    input  logic                    i_valid,
    input  logic signed [RAW_W-1:0] i_raw_reading,
    output logic                    o_stall,
    output logic                    o_job_valid,
    output t_job                    o_job,
    input  logic                    i_pop
);

    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);
    localparam logic signed [DN_W-1:0] ONE_DN = 1;

    logic signed [DN_W-1:0] w_raw;
    logic signed [DN_W-1:0] w_low;
    logic signed [DN_W-1:0] w_high;
    logic signed [DN_W-1:0] w_vref;
    logic signed [DN_W-1:0] w_dif_d;
    logic signed [DN_W-1:0] w_dif_n;
    logic signed [DN_W-1:0] w_d;
    logic signed [DN_W-1:0] w_n;
    t_job                   w_job;
    logic                   w_push;

    t_job                   r_q [QDEPTH];
    logic [QPTR_W-1:0]      r_wr_ptr;
    logic [QPTR_W-1:0]      r_rd_ptr;
    logic [QCNT_W-1:0]      r_count;

    // Divider terms, all in half counts.
    always_comb begin
        w_raw   = {{(DN_W-RAW_W){i_raw_reading[RAW_W-1]}}, i_raw_reading};
        w_low   = {{(DN_W-CAL_W){i_cfg.adc_low_cal[CAL_W-1]}}, i_cfg.adc_low_cal};
        w_high  = {{(DN_W-CAL_W){i_cfg.adc_high_cal[CAL_W-1]}}, i_cfg.adc_high_cal};
        w_vref  = DN_W'(ADC_FULL_SCALE) + w_high + w_high;
        w_dif_d = w_vref - w_raw;
        w_dif_n = w_raw - (w_low + w_low);
        w_d     = w_dif_d + w_dif_d - ONE_DN;
        w_n     = w_dif_n + w_dif_n + ONE_DN;
    end

    // Classification: simple modes and fault cases finish here.
    always_comb begin
        w_job.therm  = 1'b0;
        w_job.temp   = TEMP_ROOM;
        w_job.status = STAT_OK;
        w_job.d_val  = w_d[LOG_W-1:0];
        w_job.n_val  = w_n[LOG_W-1:0];
        unique case (i_cfg.sensor_mode)
            MODE_TC: begin
                w_job.temp = {i_raw_reading, 2'b00};
            end
            MODE_THERM: begin
                if (w_d <= 0) begin
                    w_job.temp   = TEMP_ABS_ZERO;
                    w_job.status = STAT_DEN;
                end else if (w_n <= 0 || i_cfg.pullup_ohms == '0) begin
                    w_job.temp   = TEMP_HOT;
                    w_job.status = STAT_RES;
                end else begin
                    w_job.therm = 1'b1;
                end
            end
            default: begin
                w_job.temp = TEMP_ROOM;
            end
        endcase
    end

    // Queue control.
    assign o_stall     = (r_count == QCNT_W'(QDEPTH));
    assign w_push      = i_valid & ~o_stall;
    assign o_job_valid = (r_count != '0);
    assign o_job       = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({w_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_job;
        end
    end

endmodule

### rtl/ttc_back.sv
// Back end of the thermistor temperature converter: the shared conversion engine
// and the output register. Depends on ttc_pkg.
module ttc_back import ttc_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cfg                     i_cfg,
    input  logic                     i_job_valid,
    input  t_job                     i_job,
    output logic                     o_pop,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [TEMP_W-1:0] o_temp_sixteenths,
    output logic [STAT_W-1:0]        o_conv_status
);

    localparam int LOG_ROUNDS = 40;
    localparam int DIV_BITS   = 56;
    localparam int LANES      = 3;

    localparam logic [2:0] MOP_L  = 3'd0;
    localparam logic [2:0] MOP_L2 = 3'd1;
    localparam logic [2:0] MOP_P1 = 3'd2;
    localparam logic [2:0] MOP_L3 = 3'd3;
    localparam logic [2:0] MOP_P2 = 3'd4;

    localparam logic signed [63:0] LN2_Q62  = 64'sd3196577161300663915;
    localparam logic [62:0]        MAG_MAX  = {63{1'b1}};
    localparam logic signed [64:0] SAT_HI   = 65'sh0_7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [64:0] SAT_LO   = -SAT_HI;
    localparam logic [DIV_BITS-1:0] DIV_NUM = 56'd10 << 52;
    localparam logic [56:0] ROUND_ADD = 57'd6301;
    localparam logic [56:0] Y_LIMIT   = 57'd1360719;
    localparam logic [20:0] RECIP_TEN = 21'd1677722;

    // Top set bit of a log operand.
    function automatic logic [4:0] msb_index(input logic [LOG_W-1:0] x);
        logic [4:0] idx;
        idx = '0;
        for (int i = 0; i < LOG_W; i++) begin
            if (x[i]) idx = 5'(i);
        end
        return idx;
    endfunction

    // Sum saturated to plus or minus (2^63 - 1).
    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s > SAT_HI) return SAT_HI[63:0];
        if (s < SAT_LO) return SAT_LO[63:0];
        return s[63:0];
    endfunction

    t_state r_state;
    t_state n_state;
    logic [5:0] r_cnt;
    logic [2:0] r_mop;

    logic [31:0]        r_y    [LANES];
    logic [39:0]        r_frac [LANES];
    logic [4:0]         r_e    [LANES];
    logic [LOG_W-1:0]   w_x    [LANES];
    logic [4:0]         w_e    [LANES];
    logic [63:0]        w_sq   [LANES];

    logic signed [63:0] r_s, r_l, r_l2, r_l3, r_p1, r_p2, r_rt;
    logic [62:0]        r_ua, r_ub;
    logic               r_neg;
    logic [127:0]       r_acc;
    logic [63:0]        r_rem;
    logic [DIV_BITS-1:0] r_quo;
    logic               r_sat;
    logic [20:0]        r_y21;
    logic [17:0]        r_q;
    logic signed [TEMP_W-1:0] r_res_temp;
    logic [STAT_W-1:0]  r_res_status;

    logic               r_out_valid;
    logic signed [TEMP_W-1:0] r_out_temp;
    logic [STAT_W-1:0]  r_out_status;

    logic               w_out_free;
    logic               w_load_direct;
    logic               w_load_res;
    logic signed [63:0] w_opa, w_opb, w_ua, w_ub;
    logic [31:0]        w_pa, w_pb;
    logic [63:0]        w_pp;
    logic [127:0]       w_pp_sh;
    logic [127:0]       w_shifted;
    logic [62:0]        w_mag;
    logic signed [63:0] w_mres;
    logic signed [63:0] w_rt_next;
    logic [63:0]        w_rem_sh;
    logic [56:0]        w_yr;
    logic [41:0]        w_prod;
    logic [18:0]        w_t19;
    logic [44:0]        w_lp0, w_lp1, w_lp2;

    assign w_out_free = ~r_out_valid | ~i_stall;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_job_valid && w_out_free && i_job.therm) n_state = S_LOG;
            S_LOG:  if (r_cnt == 6'(LOG_ROUNDS - 1)) n_state = S_SUM;
            S_SUM:  n_state = S_MSET;
            S_MSET: n_state = S_MPP;
            S_MPP:  if (r_cnt[1:0] == 2'd3) n_state = S_MFIN;
            S_MFIN: n_state = (r_mop == MOP_P2) ? S_ADD1 : S_MSET;
            S_ADD1: n_state = S_ADD2;
            S_ADD2: n_state = (w_rt_next <= 0) ? S_DONE : S_DIV;
            S_DIV:  if (r_cnt == 6'(DIV_BITS - 1)) n_state = S_RND1;
            S_RND1: n_state = S_RND2;
            S_RND2: n_state = S_RND3;
            S_RND3: n_state = S_DONE;
            S_DONE: if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control outputs.
    always_comb begin
        o_pop         = (r_state == S_IDLE) && i_job_valid && w_out_free;
        w_load_direct = o_pop && !i_job.therm;
        w_load_res    = (r_state == S_DONE) && w_out_free;
    end

    // State, step counter and multiply sequence index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_mop   <= MOP_L;
        end else begin
            r_state <= n_state;
            r_cnt   <= (n_state != r_state) ? 6'd0 : r_cnt + 6'd1;
            if (r_state == S_SUM) begin
                r_mop <= MOP_L;
            end else if (r_state == S_MFIN) begin
                r_mop <= r_mop + 3'd1;
            end
        end
    end

    // Log lanes: pull-up, numerator and denominator, one squaring per cycle.
    always_comb begin
        w_x[0] = i_cfg.pullup_ohms;
        w_x[1] = i_job.n_val;
        w_x[2] = i_job.d_val;
        for (int k = 0; k < LANES; k++) begin
            w_e[k]  = msb_index(w_x[k]);
            w_sq[k] = r_y[k] * r_y[k];
        end
        w_lp0 = {r_e[0], r_frac[0]};
        w_lp1 = {r_e[1], r_frac[1]};
        w_lp2 = {r_e[2], r_frac[2]};
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < LANES; k++) begin
            if (o_pop) begin
                r_e[k]    <= w_e[k];
                r_y[k]    <= {{(32-LOG_W){1'b0}}, w_x[k]} << (5'd31 - w_e[k]);
                r_frac[k] <= '0;
            end else if (r_state == S_LOG) begin
                if (w_sq[k][63]) begin
                    r_y[k]    <= w_sq[k][63:32];
                    r_frac[k] <= {r_frac[k][38:0], 1'b1};
                end else begin
                    r_y[k]    <= w_sq[k][62:31];
                    r_frac[k] <= {r_frac[k][38:0], 1'b0};
                end
            end
        end
    end

    // Multiply operands for each step of the sequence.
    always_comb begin
        case (r_mop)
            MOP_L: begin
                w_opa = r_s;
                w_opb = LN2_Q62;
            end
            MOP_L2: begin
                w_opa = r_l;
                w_opb = r_l;
            end
            MOP_P1: begin
                w_opa = {{(64-COEF_W){i_cfg.coef_b[COEF_W-1]}}, i_cfg.coef_b};
                w_opb = r_l;
            end
            MOP_L3: begin
                w_opa = r_l2;
                w_opb = r_l;
            end
            MOP_P2: begin
                w_opa = {{(64-COEF_W){i_cfg.coef_c[COEF_W-1]}}, i_cfg.coef_c};
                w_opb = r_l3;
            end
            default: begin
                w_opa = '0;
                w_opb = '0;
            end
        endcase
        w_ua = w_opa[63] ? (64'sd0 - w_opa) : w_opa;
        w_ub = w_opb[63] ? (64'sd0 - w_opb) : w_opb;
    end

    // Partial product of the 32 by 32 multiplier and its place in the accumulator.
    always_comb begin
        w_pa = r_cnt[1] ? {1'b0, r_ua[62:32]} : r_ua[31:0];
        w_pb = r_cnt[0] ? {1'b0, r_ub[62:32]} : r_ub[31:0];
        w_pp = w_pa * w_pb;
        case (r_cnt[1:0]) inside
            2'd0:       w_pp_sh = {64'd0, w_pp};
            2'd1, 2'd2: w_pp_sh = {32'd0, w_pp, 32'd0};
            default:    w_pp_sh = {w_pp, 64'd0};
        endcase
    end

    // Truncating shift, saturation and sign of the finished product.
    always_comb begin
        w_shifted = (r_mop == MOP_L) ? (r_acc >> 62) : (r_acc >> 40);
        w_mag     = (|w_shifted[127:63]) ? MAG_MAX : w_shifted[62:0];
        w_mres    = r_neg ? (64'sd0 - $signed({1'b0, w_mag})) : $signed({1'b0, w_mag});
    end

    // Sum, division and rounding terms.
    always_comb begin
        w_rt_next = sat_add(r_rt, r_p2);
        w_rem_sh  = {r_rem[62:0], DIV_NUM[6'(DIV_BITS - 1) - r_cnt]};
        w_yr      = {1'b0, r_quo} + ROUND_ADD;
        w_prod    = r_y21 * RECIP_TEN;
        w_t19     = {1'b0, r_q} - 19'd5000;
    end

    // Engine datapath.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_SUM: begin
                r_s <= $signed({19'd0, w_lp0}) + $signed({19'd0, w_lp1})
                       - $signed({19'd0, w_lp2});
            end
            S_MSET: begin
                r_ua  <= w_ua[62:0];
                r_ub  <= w_ub[62:0];
                r_neg <= w_opa[63] ^ w_opb[63];
                r_acc <= '0;
            end
            S_MPP: begin
                r_acc <= r_acc + w_pp_sh;
            end
            S_MFIN: begin
                case (r_mop)
                    MOP_L:   r_l  <= w_mres;
                    MOP_L2:  r_l2 <= w_mres;
                    MOP_P1:  r_p1 <= w_mres;
                    MOP_L3:  r_l3 <= w_mres;
                    default: r_p2 <= w_mres;
                endcase
            end
            S_ADD1: begin
                r_rt <= sat_add({{(64-COEF_W){i_cfg.coef_a[COEF_W-1]}}, i_cfg.coef_a}, r_p1);
            end
            S_ADD2: begin
                r_rt         <= w_rt_next;
                r_rem        <= '0;
                r_quo        <= '0;
                r_res_temp   <= TEMP_HOT;
                r_res_status <= STAT_RECIP;
            end
            S_DIV: begin
                if (w_rem_sh >= $unsigned(r_rt)) begin
                    r_rem <= w_rem_sh - $unsigned(r_rt);
                    r_quo <= {r_quo[DIV_BITS-2:0], 1'b1};
                end else begin
                    r_rem <= w_rem_sh;
                    r_quo <= {r_quo[DIV_BITS-2:0], 1'b0};
                end
            end
            S_RND1: begin
                r_sat <= (w_yr > Y_LIMIT);
                r_y21 <= w_yr[20:0];
            end
            S_RND2: begin
                r_q <= w_prod[41:24];
            end
            S_RND3: begin
                r_res_temp   <= r_sat ? TEMP_MAX : $signed(w_t19[TEMP_W-1:0]);
                r_res_status <= STAT_OK;
            end
            default: ;
        endcase
    end

    // Output register: holds a result until it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_direct || w_load_res) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_direct) begin
            r_out_temp   <= i_job.temp;
            r_out_status <= i_job.status;
        end else if (w_load_res) begin
            r_out_temp   <= r_res_temp;
            r_out_status <= r_res_status;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_temp_sixteenths = r_out_temp;
    assign o_conv_status     = r_out_status;

endmodule

### rtl/thermistor_temperature_convert.sv
// Top level of the thermistor temperature converter.
// Joins the register file, the front end and the conversion engine; depends on ttc_pkg.
//
// Usage:
// Raw readings enter on i_valid / o_stall / i_raw_reading, and each gives one result
// transfer on o_valid / i_stall with o_temp_sixteenths and o_conv_status.
// Registers are written over the APB-style port at byte address 8 * index, 64-bit data.
// The front end classifies each reading at once and puts it into a two-entry queue,
// so readings are taken while the engine is busy or a result waits to be taken.
// Thermocouple, fixed and fault cases leave the queue one per cycle while the engine
// is idle and the output is free; each passes from the queue into the output register.
// A thermistor conversion holds the shared engine through 40 log squaring rounds in
// three parallel lanes, five 64-bit products on one 32 by 32 multiplier and a 56-bit
// restoring division; a non-positive recipT skips the division and rounding.
// The output register holds its result while i_stall is high; the engine then waits
// with its finished result, and o_stall rises once the queue is full.
// Reset empties the queue and the output, idles the engine and loads register defaults.
module thermistor_temperature_convert import ttc_pkg::*; #(
    parameter int ADC_FULL_SCALE = ADC_FULL_SCALE_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [PADDR_W-1:0]       paddr,
    input  logic [PDATA_W-1:0]       pwdata,
    output logic [PDATA_W-1:0]       prdata,
    output logic                     pready,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic signed [RAW_W-1:0]  i_raw_reading,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [TEMP_W-1:0] o_temp_sixteenths,
    output logic [STAT_W-1:0]        o_conv_status
);

    t_cfg w_cfg;
    t_job w_job;
    logic w_job_valid;
    logic w_pop;

    // Configuration registers.
    ttc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Classification and job queue.
    ttc_front #(
        .ADC_FULL_SCALE (ADC_FULL_SCALE)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_valid       (i_valid),
        .i_raw_reading (i_raw_reading),
        .o_stall       (o_stall),
        .o_job_valid   (w_job_valid),
        .o_job         (w_job),
        .i_pop         (w_pop)
    );

    // Conversion engine and output register.
    ttc_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (w_cfg),
        .i_job_valid       (w_job_valid),
        .i_job             (w_job),
        .o_pop             (w_pop),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_temp_sixteenths (o_temp_sixteenths),
        .o_conv_status     (o_conv_status)
    );

    // A job is only taken from the queue when one is there.
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_job_valid)
        else $error("job taken from an empty queue");

    // A denominator fault always reports absolute zero.
    a_den_temp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_conv_status == STAT_DEN) |-> (o_temp_sixteenths == TEMP_ABS_ZERO))
        else $error("denominator fault without absolute zero");

    // RecipT and resistance faults always report 2000 degrees.
    a_hot_temp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_conv_status == STAT_RECIP || o_conv_status == STAT_RES))
        |-> (o_temp_sixteenths == TEMP_HOT))
        else $error("fault result without 2000 degrees");

endmodule
